FILE: rtl/rts_pkg.sv
`default_nettype none
package rts_pkg;

    localparam int LEN_W        = 16;
    localparam int FRAC_W       = 8;
    localparam int SQ_W         = 2 * LEN_W;
    localparam int RES_W        = 17;
    localparam int STAT_W       = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int SQRT_STEPS   = 33;
    localparam int RAD_W        = 2 * SQRT_STEPS;
    localparam int ROOT_W       = SQRT_STEPS;
    localparam int REM_W        = ROOT_W + 3;
    localparam int SCALE_W      = 32 - LEN_W;
    localparam int CORDIC_STEPS = 20;
    localparam int XY_W         = 36;
    localparam int Z_W          = 25;
    localparam int ANGLE_SHIFT  = 16 - FRAC_W;
    localparam int ANGLE_HALF   = (ANGLE_SHIFT == 0) ? 0 : (1 << (ANGLE_SHIFT - 1));
    localparam int ANGLE_MAX    = 90 * 65536;
    localparam int RES_MAX      = (1 << RES_W) - 1;

    typedef enum logic [1:0] {
        CMD_HYP    = 2'd0,
        CMD_LEG    = 2'd1,
        CMD_ANGLE  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FEW_SIDES = 2'd1,
        STAT_HYP_SHORT = 2'd2,
        STAT_LEG_LONG  = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HYP,
        OP_LEG,
        OP_ASIN,
        OP_ACOS,
        OP_ATAN
    } op_t;

    typedef struct packed {
        op_t              op;
        stat_t            status;
        logic [SQ_W-1:0]  sq_p;
        logic [SQ_W-1:0]  sq_q;
        logic [LEN_W-1:0] opp;
        logic [LEN_W-1:0] adj;
    } item_t;

    typedef struct packed {
        op_t   op;
        stat_t status;
    } meta_t;

    function automatic logic signed [Z_W-1:0] atan_deg16(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 25'sd2949120;
            1:       v = 25'sd1740967;
            2:       v = 25'sd919879;
            3:       v = 25'sd466945;
            4:       v = 25'sd234379;
            5:       v = 25'sd117304;
            6:       v = 25'sd58666;
            7:       v = 25'sd29335;
            8:       v = 25'sd14668;
            9:       v = 25'sd7334;
            10:      v = 25'sd3667;
            11:      v = 25'sd1833;
            12:      v = 25'sd917;
            13:      v = 25'sd458;
            14:      v = 25'sd229;
            15:      v = 25'sd115;
            16:      v = 25'sd57;
            17:      v = 25'sd29;
            18:      v = 25'sd14;
            19:      v = 25'sd7;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // shift toward zero
    function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                       input int s);
        logic signed [XY_W-1:0] r;
        if (v < 0)
        begin
            r = -((-v) >>> s);
        end
        else
        begin
            r = v >>> s;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rts_front.sv
`default_nettype none
module rts_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                command,
    input  wire logic [rts_pkg::LEN_W-1:0] opposite_len,
    input  wire logic [rts_pkg::LEN_W-1:0] adjacent_len,
    input  wire logic [rts_pkg::LEN_W-1:0] hyp_len,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output rts_pkg::item_t                 push_item
);
    import rts_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    item_t            item_reg;
    item_t            item_next;
    op_t              op;
    stat_t            st;
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] q;
    logic [1:0]       known;
    logic             accept;

    assign in_ready   = !vld_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = vld_reg;
    assign push_item  = item_reg;

    assign known = {1'b0, opposite_len != '0} + {1'b0, adjacent_len != '0}
                 + {1'b0, hyp_len != '0};

    // classify the request and pick the two operands to square
    always_comb
    begin
        op = OP_NONE;
        st = STAT_OK;
        p  = '0;
        q  = '0;
        case (cmd_t'(command))
            CMD_HYP:
            begin
                op = OP_HYP;
                p  = opposite_len;
                q  = adjacent_len;
            end
            CMD_LEG:
            begin
                if (adjacent_len > hyp_len)
                begin
                    st = STAT_LEG_LONG;
                end
                else
                begin
                    op = OP_LEG;
                    p  = hyp_len;
                    q  = adjacent_len;
                end
            end
            CMD_ANGLE:
            begin
                if (hyp_len != '0 && (adjacent_len >= hyp_len || opposite_len >= hyp_len))
                begin
                    st = STAT_HYP_SHORT;
                end
                else if (known < 2'd2)
                begin
                    st = STAT_FEW_SIDES;
                end
                else if (opposite_len != '0 && hyp_len != '0)
                begin
                    op = OP_ASIN;
                    p  = hyp_len;
                    q  = opposite_len;
                end
                else if (adjacent_len != '0 && hyp_len != '0)
                begin
                    op = OP_ACOS;
                    p  = hyp_len;
                    q  = adjacent_len;
                end
                else
                begin
                    op = OP_ATAN;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        item_next.op     = op;
        item_next.status = st;
        item_next.sq_p   = p * p;
        item_next.sq_q   = q * q;
        item_next.opp    = opposite_len;
        item_next.adj    = adjacent_len;
        vld_next         = accept ? 1'b1 : (push_ready ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rts_queue.sv
`default_nettype none
module rts_queue #(
    parameter int DEPTH = rts_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rts_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rts_pkg::item_t      out_item
);
    import rts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg != CNT_W'(DEPTH)) || pop;
    assign push      = in_valid && in_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rts_back.sv
`default_nettype none
module rts_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire rts_pkg::item_t            in_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [rts_pkg::RES_W-1:0]      result_value,
    output logic [rts_pkg::STAT_W-1:0]     status
);
    import rts_pkg::*;

    logic                   advance;

    // square root pipeline, index 0 is the radicand stage
    logic                   sq_vld_reg  [SQRT_STEPS+1];
    logic [RAD_W-1:0]       sq_rad_reg  [SQRT_STEPS+1];
    logic [REM_W-1:0]       sq_rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]      sq_root_reg [SQRT_STEPS+1];
    meta_t                  sq_meta_reg [SQRT_STEPS+1];
    logic [LEN_W-1:0]       sq_opp_reg  [SQRT_STEPS+1];
    logic [LEN_W-1:0]       sq_adj_reg  [SQRT_STEPS+1];

    // vectoring pipeline, index 0 is the setup stage
    logic                   cd_vld_reg  [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_x_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_y_reg    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cd_z_reg    [CORDIC_STEPS+1];
    logic [RES_W-1:0]       cd_val_reg  [CORDIC_STEPS+1];
    meta_t                  cd_meta_reg [CORDIC_STEPS+1];

    logic                   out_vld_reg;
    logic [RES_W-1:0]       out_val_reg;
    logic [RES_W-1:0]       out_val_next;
    stat_t                  out_stat_reg;

    logic [RAD_W-1:0]       rad_next;
    logic [SQ_W:0]          sq_sum;
    logic [SQ_W-1:0]        sq_diff;

    logic [ROOT_W:0]        len_round;
    logic [RES_W-1:0]       len_sat;
    logic [XY_W-1:0]        leg_ext;
    logic [XY_W-1:0]        opp_ext;
    logic [XY_W-1:0]        adj_ext;
    logic signed [XY_W-1:0] x0_next;
    logic signed [XY_W-1:0] y0_next;
    logic [RES_W-1:0]       val0_next;

    logic signed [Z_W-1:0]  z_clamp;
    logic [Z_W-1:0]         z_round;

    assign advance      = !out_vld_reg || out_ready;
    assign in_ready     = advance;
    assign out_valid    = out_vld_reg;
    assign result_value = out_val_reg;
    assign status       = out_stat_reg;

    always_comb
    begin
        sq_sum  = {1'b0, in_item.sq_p} + {1'b0, in_item.sq_q};
        sq_diff = in_item.sq_p - in_item.sq_q;
        case (in_item.op)
            OP_HYP:            rad_next = RAD_W'(sq_sum);
            OP_LEG:            rad_next = RAD_W'(sq_diff);
            OP_ASIN, OP_ACOS:  rad_next = RAD_W'({sq_diff, {(2 * SCALE_W){1'b0}}});
            default:           rad_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            sq_vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_rad_reg[0]  <= rad_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_meta_reg[0] <= '{op: in_item.op, status: in_item.status};
            sq_opp_reg[0]  <= in_item.opp;
            sq_adj_reg[0]  <= in_item.adj;
        end
    end

    // one root bit per stage
    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign cur   = {sq_rem_reg[k-1][REM_W-3:0], sq_rad_reg[k-1][RAD_W-1 -: 2]};
        assign trial = REM_W'({sq_root_reg[k-1], 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sq_rad_reg[k]  <= {sq_rad_reg[k-1][RAD_W-3:0], 2'b00};
                sq_rem_reg[k]  <= ge ? cur - trial : cur;
                sq_root_reg[k] <= {sq_root_reg[k-1][ROOT_W-2:0], ge};
                sq_meta_reg[k] <= sq_meta_reg[k-1];
                sq_opp_reg[k]  <= sq_opp_reg[k-1];
                sq_adj_reg[k]  <= sq_adj_reg[k-1];
            end
        end
    end

    always_comb
    begin
        len_round = {1'b0, sq_root_reg[SQRT_STEPS]}
                  + (ROOT_W + 1)'(sq_rem_reg[SQRT_STEPS] > REM_W'(sq_root_reg[SQRT_STEPS]));
        len_sat   = (len_round > (ROOT_W + 1)'(RES_MAX)) ? RES_W'(RES_MAX)
                                                        : len_round[RES_W-1:0];
        leg_ext   = XY_W'(sq_root_reg[SQRT_STEPS][31:0]);
        opp_ext   = XY_W'({sq_opp_reg[SQRT_STEPS], {SCALE_W{1'b0}}});
        adj_ext   = XY_W'({sq_adj_reg[SQRT_STEPS], {SCALE_W{1'b0}}});
        x0_next   = adj_ext;
        y0_next   = opp_ext;
        val0_next = '0;
        case (sq_meta_reg[SQRT_STEPS].op)
            OP_HYP, OP_LEG: val0_next = len_sat;
            OP_ASIN:        x0_next   = leg_ext;
            OP_ACOS:        y0_next   = leg_ext;
            default:        val0_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            cd_vld_reg[0] <= sq_vld_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cd_x_reg[0]    <= x0_next;
            cd_y_reg[0]    <= y0_next;
            cd_z_reg[0]    <= '0;
            cd_val_reg[0]  <= val0_next;
            cd_meta_reg[0] <= sq_meta_reg[SQRT_STEPS];
        end
    end

    for (genvar i = 1; i <= CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic                   pos;

        assign dx  = shr_tz(cd_y_reg[i-1], i - 1);
        assign dy  = shr_tz(cd_x_reg[i-1], i - 1);
        assign pos = cd_y_reg[i-1] >= 0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_vld_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                cd_vld_reg[i] <= cd_vld_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                cd_x_reg[i]    <= pos ? cd_x_reg[i-1] + dx : cd_x_reg[i-1] - dx;
                cd_y_reg[i]    <= pos ? cd_y_reg[i-1] - dy : cd_y_reg[i-1] + dy;
                cd_z_reg[i]    <= pos ? cd_z_reg[i-1] + atan_deg16(i - 1)
                                      : cd_z_reg[i-1] - atan_deg16(i - 1);
                cd_val_reg[i]  <= cd_val_reg[i-1];
                cd_meta_reg[i] <= cd_meta_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (cd_z_reg[CORDIC_STEPS] < 0)
        begin
            z_clamp = '0;
        end
        else if (cd_z_reg[CORDIC_STEPS] > Z_W'(ANGLE_MAX))
        begin
            z_clamp = Z_W'(ANGLE_MAX);
        end
        else
        begin
            z_clamp = cd_z_reg[CORDIC_STEPS];
        end
        z_round = (Z_W'(z_clamp) + Z_W'(ANGLE_HALF)) >> ANGLE_SHIFT;
        case (cd_meta_reg[CORDIC_STEPS].op)
            OP_ASIN, OP_ACOS, OP_ATAN: out_val_next = z_round[RES_W-1:0];
            default:                   out_val_next = cd_val_reg[CORDIC_STEPS];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= cd_vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_val_reg  <= out_val_next;
            out_stat_reg <= cd_meta_reg[CORDIC_STEPS].status;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/right_triangle_solver.sv
// right triangle solver
// input channel: in_valid / in_ready carry command, opposite_len, adjacent_len
// and hyp_len (unsigned q8.8, zero means unknown); a request is taken on an
// edge where both are high
// output channel: out_valid / out_ready carry result_value and status, one
// result per request, in request order
// one request per cycle is sustained while out_ready is high
// each request passes through the input register, the two-entry queue, the
// 33-stage bit-per-stage square root, the 20-stage cordic vectoring chain
// and the output register
// reset clears all valid flags; no results are pending afterwards
// when the receiver holds out_ready low the whole back pipeline holds, the
// queue and input register fill, and in_ready drops only while the output
// is waiting
`default_nettype none
module right_triangle_solver #(
    parameter int QUEUE_DEPTH = rts_pkg::QUEUE_DEPTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                command,
    input  wire logic [rts_pkg::LEN_W-1:0] opposite_len,
    input  wire logic [rts_pkg::LEN_W-1:0] adjacent_len,
    input  wire logic [rts_pkg::LEN_W-1:0] hyp_len,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [rts_pkg::RES_W-1:0]      result_value,
    output logic [rts_pkg::STAT_W-1:0]     status
);
    import rts_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    rts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .opposite_len (opposite_len),
        .adjacent_len (adjacent_len),
        .hyp_len      (hyp_len),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    rts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_item  (pop_item)
    );

    rts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pop_valid),
        .in_ready     (pop_ready),
        .in_item      (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status)
    );

endmodule
`default_nettype wire

FILE: rtl/rts_checker.sv
`default_nettype none
module rts_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic [1:0]                command,
    input wire logic [rts_pkg::LEN_W-1:0] opposite_len,
    input wire logic [rts_pkg::LEN_W-1:0] adjacent_len,
    input wire logic [rts_pkg::LEN_W-1:0] hyp_len,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [rts_pkg::RES_W-1:0] result_value,
    input wire logic [rts_pkg::STAT_W-1:0] status
);
    import rts_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> result_value == '0)
        else $error("error result carries a value");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output stall");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(command) && $stable(opposite_len)
                                  && $stable(adjacent_len) && $stable(hyp_len))
        else $error("request changed while waiting");

endmodule

bind right_triangle_solver rts_checker u_chk (.*);
`default_nettype wire

FILE: test/right_triangle_solver_test.sv
`timescale 1ns / 1ps
module right_triangle_solver_test;
    import rts_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] opp;
        logic [15:0] adj;
        logic [15:0] hyp;
    } request_t;

    typedef struct {
        logic [16:0] value;
        stat_t       stat;
    } solution_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] command;
    logic [15:0] opposite_len;
    logic [15:0] adjacent_len;
    logic [15:0] hyp_len;
    logic out_valid;
    logic out_ready;
    logic [16:0] result_value;
    logic [1:0] status;

    request_t pending_requests[$];
    solution_t expected_solutions[$];
    int failures;
    bit in_accepted;
    int send_gap;
    int recv_gap;

    right_triangle_solver dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .opposite_len(opposite_len),
        .adjacent_len(adjacent_len),
        .hyp_len(hyp_len),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_value(result_value),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic longint unsigned floor_root(longint unsigned v,
                                                   output longint unsigned rem);
        longint unsigned r;
        longint unsigned root;
        longint unsigned trial;
        r = 0;
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            r = (r << 2) | ((v >> (2 * k)) & 64'd3);
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (r >= trial)
            begin
                r = r - trial;
                root = root | 64'd1;
            end
        end
        rem = r;
        return root;
    endfunction

    function automatic longint unsigned nearest_root(longint unsigned v);
        longint unsigned rem;
        longint unsigned r;
        r = floor_root(v, rem);
        return (rem > r) ? r + 1 : r;
    endfunction

    function automatic longint signed atan_step(int i);
        longint signed t[20];
        t = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return t[i];
    endfunction

    function automatic longint signed toward_zero(longint signed v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic logic [16:0] degrees_of(longint signed x, longint signed y);
        longint signed z;
        longint signed dx;
        longint signed dy;
        z = 0;
        if (y == 0)
            return 17'd0;
        if (x == 0)
        begin
            z = 90 * 65536;
        end
        else
        begin
            for (int i = 0; i < 20; i++)
            begin
                dx = toward_zero(y, i);
                dy = toward_zero(x, i);
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_step(i);
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_step(i);
                end
            end
            if (z < 0)
                z = 0;
            if (z > 90 * 65536)
                z = 90 * 65536;
        end
        return 17'((z + 128) >> 8);
    endfunction

    function automatic solution_t solve_triangle(request_t rq);
        solution_t s;
        longint unsigned o;
        longint unsigned a;
        longint unsigned h;
        longint unsigned v;
        longint unsigned rem;
        longint unsigned leg;
        int known;
        o = rq.opp;
        a = rq.adj;
        h = rq.hyp;
        v = 0;
        s.stat = STAT_OK;
        known = (o != 0) + (a != 0) + (h != 0);
        case (rq.cmd)
            CMD_HYP:
                v = nearest_root(o * o + a * a);
            CMD_LEG:
                if (a > h)
                    s.stat = STAT_LEG_LONG;
                else
                    v = nearest_root(h * h - a * a);
            CMD_ANGLE:
                if (h != 0 && (a >= h || o >= h))
                    s.stat = STAT_HYP_SHORT;
                else if (known < 2)
                    s.stat = STAT_FEW_SIDES;
                else if (o != 0 && h != 0)
                begin
                    leg = floor_root((h * h - o * o) << 32, rem);
                    v = degrees_of(longint'(leg), longint'(o << 16));
                end
                else if (a != 0 && h != 0)
                begin
                    leg = floor_root((h * h - a * a) << 32, rem);
                    v = degrees_of(longint'(a << 16), longint'(leg));
                end
                else
                    v = degrees_of(longint'(a << 16), longint'(o << 16));
            default:
                v = 0;
        endcase
        s.value = (v > 64'h1FFFF) ? 17'h1FFFF : 17'(v);
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        if (r < 5)
            return 16'($urandom_range(1, 2047));
        return 16'($urandom);
    endfunction

    task automatic add_request(cmd_t c, logic [15:0] o, logic [15:0] a, logic [15:0] h);
        request_t rq;
        rq.cmd = c;
        rq.opp = o;
        rq.adj = a;
        rq.hyp = h;
        pending_requests.push_back(rq);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_accepted)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    request_t rq;
                    rq = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    command <= rq.cmd;
                    opposite_len <= rq.opp;
                    adjacent_len <= rq.adj;
                    hyp_len <= rq.hyp;
                    expected_solutions.push_back(solve_triangle(rq));
                    send_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        in_accepted <= rst_n && in_valid && in_ready;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_solutions.size() == 0)
            begin
                failures++;
                $display("%0t unexpected result: expected none, actual value %0d status %0d",
                         $time, result_value, status);
            end
            else
            begin
                solution_t s;
                s = expected_solutions.pop_front();
                if (result_value !== s.value || status !== s.stat)
                begin
                    failures++;
                    $display("%0t mismatch: expected %0d/%0d actual %0d/%0d",
                             $time, s.value, s.stat, result_value, status);
                end
            end
        end
    end

    initial
    begin
        logic [15:0] h;
        logic [15:0] o;
        int r;
        failures = 0;
        in_accepted = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = '0;
        opposite_len = '0;
        adjacent_len = '0;
        hyp_len = '0;
        rst_n = 1'b0;

        add_request(CMD_HYP, 16'hFFFF, 16'hFFFF, 16'd0);
        add_request(CMD_HYP, 16'd0, 16'd0, 16'd0);
        add_request(CMD_HYP, 16'd768, 16'd1024, 16'd0);
        add_request(CMD_LEG, 16'd0, 16'd1024, 16'd768);
        add_request(CMD_LEG, 16'd0, 16'd1024, 16'd1024);
        add_request(CMD_LEG, 16'd0, 16'd768, 16'd1280);
        add_request(CMD_LEG, 16'd0, 16'd0, 16'hFFFF);
        add_request(CMD_LEG, 16'hFFFF, 16'd1, 16'hFFFF);
        add_request(CMD_ANGLE, 16'd1024, 16'd0, 16'd1024);
        add_request(CMD_ANGLE, 16'd0, 16'd2000, 16'd1000);
        add_request(CMD_ANGLE, 16'd500, 16'd0, 16'd0);
        add_request(CMD_ANGLE, 16'd0, 16'd0, 16'd0);
        add_request(CMD_ANGLE, 16'd768, 16'd0, 16'd1280);
        add_request(CMD_ANGLE, 16'd0, 16'd768, 16'd1280);
        add_request(CMD_ANGLE, 16'd768, 16'd1024, 16'd0);
        add_request(CMD_ANGLE, 16'd1, 16'd0, 16'hFFFF);
        add_request(CMD_ANGLE, 16'hFFFE, 16'd0, 16'hFFFF);
        add_request(CMD_ANGLE, 16'd0, 16'd1, 16'hFFFF);
        add_request(CMD_ANGLE, 16'hFFFF, 16'd1, 16'd0);
        add_request(CMD_ANGLE, 16'd1, 16'hFFFF, 16'd0);
        add_request(CMD_ANGLE, 16'd256, 16'd256, 16'd0);
        add_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_request(CMD_UNUSED, 16'd0, 16'd0, 16'd0);

        for (int n = 0; n < 1950; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                add_request(CMD_HYP, pick_len(), pick_len(), pick_len());
            else if (r < 40)
            begin
                h = pick_len();
                o = (h > 0 && $urandom_range(0, 3) != 0) ? 16'($urandom_range(0, h))
                                                         : pick_len();
                add_request(CMD_LEG, pick_len(), o, h);
            end
            else if (r < 90)
            begin
                h = pick_len();
                if (h < 2)
                    h = 16'($urandom_range(2, 65535));
                o = 16'($urandom_range(1, h - 1));
                case ($urandom_range(0, 3))
                    0: add_request(CMD_ANGLE, o, 16'd0, h);
                    1: add_request(CMD_ANGLE, 16'd0, o, h);
                    2: add_request(CMD_ANGLE, pick_len(), pick_len(), 16'd0);
                    default: add_request(CMD_ANGLE, pick_len(), pick_len(), pick_len());
                endcase
            end
            else
                add_request(cmd_t'($urandom_range(0, 3)), pick_len(), pick_len(), pick_len());
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (in_valid && !in_ready)
            @(posedge clk);
        @(posedge clk);
        while (expected_solutions.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (failures == 0)
            $display("right_triangle_solver_test: PASS");
        else
            $display("right_triangle_solver_test: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("right_triangle_solver_test: FAIL");
        $finish;
    end

endmodule
